// ===== rtl/core/gcbb_pkg.sv =====
`default_nettype none

package gcbb_pkg;

  // Largest glyph dimension; counters hold 0 .. MAX_DIM-1
  localparam int unsigned MAX_DIM = 1024;
  localparam int unsigned CNT_W   = $clog2(MAX_DIM);
  localparam int unsigned DIM_W   = 11;
  localparam int unsigned COV_W   = 8;
  localparam int unsigned PIX_W   = 32;
  localparam int unsigned OFFS_W  = 20;
  localparam int unsigned COL_W   = 24;
  localparam int unsigned CFG_W   = 24;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [DIM_W-1:0] CLIP_W_RST   = DIM_W'(480);
  localparam logic [DIM_W-1:0] CLIP_H_RST   = DIM_W'(272);
  localparam logic [DIM_W-1:0] LINE_SIZE_RST = DIM_W'(512);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEXT_COLOR  = 3'd0,
    CFG_GLYPH_WIDTH = 3'd1,
    CFG_GLYPH_ROWS  = 3'd2,
    CFG_X_OFFSET    = 3'd3,
    CFG_Y_OFFSET    = 3'd4,
    CFG_CLIP_WIDTH  = 3'd5,
    CFG_CLIP_HEIGHT = 3'd6,
    CFG_LINE_SIZE   = 3'd7
  } cfg_reg_e;

  // x/255 for x <= 255*255: (x + 1 + x/256) / 256
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] s;
    s = {1'b0, x} + 17'd1 + {9'b0, x[15:8]};
    return s[15:8];
  endfunction

  // One colour channel: text*cov/255 + (255-cov)*dst/255, each term truncated
  function automatic logic [7:0] mix(input logic [7:0] text, input logic [7:0] cov,
                                     input logic [7:0] dst);
    logic [15:0] pt;
    logic [15:0] pd;
    logic [8:0]  sum;
    pt  = {8'b0, text} * {8'b0, cov};
    pd  = {8'b0, 8'hff - cov} * {8'b0, dst};
    sum = {1'b0, div255(pt)} + {1'b0, div255(pd)};
    return sum[7:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/gcbb_if.sv =====
`default_nettype none

interface gcbb_pix_if;
  import gcbb_pkg::*;
  logic               valid;
  logic               ready;
  logic [COV_W-1:0]   coverage;
  logic [PIX_W-1:0]   dest_pixel;

  modport source (output valid, output coverage, output dest_pixel, input ready);
  modport sink   (input valid, input coverage, input dest_pixel, output ready);
endinterface

interface gcbb_res_if;
  import gcbb_pkg::*;
  logic               valid;
  logic               ready;
  logic [PIX_W-1:0]   new_pixel;
  logic               write_enable;
  logic [OFFS_W-1:0]  pixel_offset;
  logic               last;

  modport source (output valid, output new_pixel, output write_enable,
                  output pixel_offset, output last, input ready);
  modport sink   (input valid, input new_pixel, input write_enable,
                  input pixel_offset, input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/glyph_coverage_blend_blit_unit.sv =====
`default_nettype none

// Glyph coverage blend blitter. Takes one request per cycle on pix_i while pix_i.ready
// is high (coverage byte plus the destination RGBA8888 word, raster order, no row
// padding) and returns one result per request on res_o, in order; throughput is one
// pixel per clock while res_o.ready is high. The two pipeline registers are the
// position stage (column/row counters, clip test, last flag) and the blend stage (three
// 8x8 channel mixes with divide-by-255 and the row*stride+column offset multiply).
// pix_i.ready follows res_o.ready combinationally through the two stages, so a stalled
// sink holds both stages and then the source. Outside the clip rectangle write_enable
// is low, new_pixel is the destination word and pixel_offset is zero. A glyph of zero
// width or rows flags every pixel last and writes nothing. The user writes registers
// through cfg_we_i/cfg_idx_i/cfg_data_i only while the pipe is empty; the block does not enforce it.
module glyph_coverage_blend_blit_unit
  import gcbb_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  gcbb_pix_if.sink                  pix_i,
  gcbb_res_if.source                res_o
);

  // ---------------- configuration registers ----------------
  logic [COL_W-1:0]        text_color_q;
  logic [DIM_W-1:0]        glyph_width_q;
  logic [DIM_W-1:0]        glyph_rows_q;
  logic signed [DIM_W-1:0] x_offset_q;
  logic signed [DIM_W-1:0] y_offset_q;
  logic [DIM_W-1:0]        clip_width_q;
  logic [DIM_W-1:0]        clip_height_q;
  logic [DIM_W-1:0]        line_size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_color_q  <= '0;
      glyph_width_q <= '0;
      glyph_rows_q  <= '0;
      x_offset_q    <= '0;
      y_offset_q    <= '0;
      clip_width_q  <= CLIP_W_RST;
      clip_height_q <= CLIP_H_RST;
      line_size_q   <= LINE_SIZE_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_TEXT_COLOR:  text_color_q  <= cfg_data_i[COL_W-1:0];
        CFG_GLYPH_WIDTH: glyph_width_q <= cfg_data_i[DIM_W-1:0];
        CFG_GLYPH_ROWS:  glyph_rows_q  <= cfg_data_i[DIM_W-1:0];
        CFG_X_OFFSET:    x_offset_q    <= cfg_data_i[DIM_W-1:0];
        CFG_Y_OFFSET:    y_offset_q    <= cfg_data_i[DIM_W-1:0];
        CFG_CLIP_WIDTH:  clip_width_q  <= cfg_data_i[DIM_W-1:0];
        CFG_CLIP_HEIGHT: clip_height_q <= cfg_data_i[DIM_W-1:0];
        CFG_LINE_SIZE:   line_size_q   <= cfg_data_i[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- handshake / stage enables ----------------
  logic s1_valid_q;
  logic res_valid_q;
  logic res_load;   // blend stage takes a new value
  logic s1_load;    // position stage takes a new request
  logic in_acc;

  assign res_load    = !res_valid_q || res_o.ready;
  assign s1_load     = !s1_valid_q || res_load;
  assign pix_i.ready = s1_load;
  assign in_acc      = pix_i.valid && s1_load;

  // ---------------- position stage ----------------
  logic [CNT_W-1:0] col_q, col_d;
  logic [CNT_W-1:0] row_q, row_d;

  logic [DIM_W-1:0] w_clamp, h_clamp;
  logic             dim_zero;
  logic [DIM_W-1:0] col_inc, row_inc;
  logic             col_end, row_end;
  logic [DIM_W:0]   sx, sy;     // signed screen position, one bit of headroom
  logic             in_clip;

  always_comb begin
    w_clamp  = (glyph_width_q > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : glyph_width_q;
    h_clamp  = (glyph_rows_q  > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : glyph_rows_q;
    dim_zero = (w_clamp == '0) || (h_clamp == '0);

    col_inc = {1'b0, col_q} + DIM_W'(1);
    row_inc = {1'b0, row_q} + DIM_W'(1);
    col_end = col_inc >= w_clamp;
    row_end = row_inc >= h_clamp;

    sx = {{(DIM_W+1-CNT_W){1'b0}}, col_q} + {x_offset_q[DIM_W-1], x_offset_q};
    sy = {{(DIM_W+1-CNT_W){1'b0}}, row_q} + {y_offset_q[DIM_W-1], y_offset_q};

    in_clip = !dim_zero
              && !sx[DIM_W] && (sx[DIM_W-1:0] < clip_width_q)
              && !sy[DIM_W] && (sy[DIM_W-1:0] < clip_height_q);

    // counters wrap as if at the final index once they reach a lowered dimension
    if (dim_zero) begin
      col_d = '0;
      row_d = '0;
    end else if (col_end) begin
      col_d = '0;
      row_d = row_end ? '0 : row_inc[CNT_W-1:0];
    end else begin
      col_d = col_inc[CNT_W-1:0];
      row_d = row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_acc) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  logic [COV_W-1:0] s1_cov_q;
  logic [PIX_W-1:0] s1_dst_q;
  logic [DIM_W-1:0] s1_sx_q, s1_sy_q;
  logic             s1_inside_q;
  logic             s1_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_load) begin
      s1_valid_q <= pix_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_cov_q    <= pix_i.coverage;
      s1_dst_q    <= pix_i.dest_pixel;
      s1_sx_q     <= sx[DIM_W-1:0];
      s1_sy_q     <= sy[DIM_W-1:0];
      s1_inside_q <= in_clip;
      s1_last_q   <= dim_zero || (col_end && row_end);
    end
  end

  // ---------------- blend stage ----------------
  logic [2*DIM_W-1:0] row_base;
  logic [OFFS_W-1:0]  offs;
  logic [PIX_W-1:0]   blended;

  always_comb begin
    row_base = {{DIM_W{1'b0}}, s1_sy_q} * {{DIM_W{1'b0}}, line_size_q};
    offs     = row_base[OFFS_W-1:0] + {{(OFFS_W-DIM_W){1'b0}}, s1_sx_q};
    blended  = {s1_dst_q[31:24],
                mix(text_color_q[23:16], s1_cov_q, s1_dst_q[23:16]),
                mix(text_color_q[15:8],  s1_cov_q, s1_dst_q[15:8]),
                mix(text_color_q[7:0],   s1_cov_q, s1_dst_q[7:0])};
  end

  logic [PIX_W-1:0]  res_pix_q;
  logic              res_we_q;
  logic [OFFS_W-1:0] res_offs_q;
  logic              res_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_load) begin
      res_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load && s1_valid_q) begin
      res_pix_q  <= s1_inside_q ? blended : s1_dst_q;
      res_we_q   <= s1_inside_q;
      res_offs_q <= s1_inside_q ? offs : '0;
      res_last_q <= s1_last_q;
    end
  end

  assign res_o.valid        = res_valid_q;
  assign res_o.new_pixel    = res_pix_q;
  assign res_o.write_enable = res_we_q;
  assign res_o.pixel_offset = res_offs_q;
  assign res_o.last         = res_last_q;

`ifndef SYNTHESIS
  // skipped pixels never carry an address
  a_skip_no_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.write_enable) |-> (res_o.pixel_offset == '0))
    else $error("skipped pixel carries a non-zero offset");

  // a full pipe behind a stalled sink must stall the source
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && res_o.valid && !res_o.ready) |-> !pix_i.ready)
    else $error("request taken while both stages are held");

  // an empty glyph leaves the counters parked at zero
  a_empty_glyph: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && dim_zero) |=> (col_q == '0 && row_q == '0))
    else $error("counters moved on an empty glyph");

  // column steps by one inside a row
  a_col_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !dim_zero && !col_end) |=> (col_q == $past(col_q) + CNT_W'(1)))
    else $error("column counter did not advance by one");
`endif

endmodule

`default_nettype wire
